/* sv/csc_pkg.sv */
// Shared constants, arctangent table and start-vector helper for the CORDIC sine/cosine unit.
package csc_pkg;

    localparam int CSC_ROTATION_STEPS = 20;
    localparam int CSC_FRACTION_BITS  = 16;

    localparam int CSC_ANGLE_W = 24;
    localparam int CSC_OUT_W   = 18;
    // Residual angle: input range plus the sum of the table, one extra bit of margin.
    localparam int CSC_Z_W     = 26;
    // x and y stay below about 1.0 in magnitude; extra bits cover the sign and growth.
    localparam int CSC_XY_GUARD = 3;

    localparam int CSC_ATAN_LEN = 24;

    localparam longint CSC_START_GAIN_Q32 = 64'sd2608131496;
    localparam longint CSC_OUT_MIN = -64'sd131072;
    localparam longint CSC_OUT_MAX = 64'sd131071;

    typedef logic [CSC_Z_W-1:0] t_csc_atan_tab [CSC_ATAN_LEN];

    // atan(2^-i) in degrees, Q16
    localparam t_csc_atan_tab CSC_ATAN_DEG_Q16 = '{
        26'd2949120, 26'd1740967, 26'd919879, 26'd466945,
        26'd234379,  26'd117304,  26'd58666,  26'd29335,
        26'd14668,   26'd7334,    26'd3667,   26'd1833,
        26'd917,     26'd458,     26'd229,    26'd115,
        26'd57,      26'd29,      26'd14,     26'd7,
        26'd4,       26'd2,       26'd1,      26'd0
    };

    // Gain-compensated start x, rounded half up from the Q32 constant.
    function automatic longint csc_start_x(input int frac);
        longint drop;
        drop = 64'(32 - frac);
        return (CSC_START_GAIN_Q32 + (64'sd1 <<< (drop - 1))) >>> drop;
    endfunction

endpackage

/* sv/csc_cell.sv */
// One micro-rotation cell of the CORDIC chain, with its own pipeline register.
module csc_cell
    import csc_pkg::*;
#(
    parameter int FRACTION_BITS = CSC_FRACTION_BITS,
    parameter int STEP_IDX      = 0
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_stall,
    input  logic signed [FRACTION_BITS+CSC_XY_GUARD-1:0] i_x,
    input  logic signed [FRACTION_BITS+CSC_XY_GUARD-1:0] i_y,
    input  logic signed [CSC_Z_W-1:0]                  i_z,
    output logic                                       o_valid,
    input  logic                                       i_stall,
    output logic signed [FRACTION_BITS+CSC_XY_GUARD-1:0] o_x,
    output logic signed [FRACTION_BITS+CSC_XY_GUARD-1:0] o_y,
    output logic signed [CSC_Z_W-1:0]                  o_z
);

    localparam int XW = FRACTION_BITS + CSC_XY_GUARD;
    localparam logic signed [CSC_Z_W-1:0] ATAN = CSC_ATAN_DEG_Q16[STEP_IDX];

    logic                      r_valid;
    logic signed [XW-1:0]      r_x, r_y, n_x, n_y;
    logic signed [CSC_Z_W-1:0] r_z, n_z;
    logic signed [XW-1:0]      w_xs, w_ys;
    logic                      w_advance;

    assign w_xs = i_x >>> STEP_IDX;
    assign w_ys = i_y >>> STEP_IDX;

    // Negative residual turns clockwise; zero counts as positive.
    always_comb begin
        if (i_z[CSC_Z_W-1]) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ATAN;
        end
    end

    // Hold while a word sits here and the next cell is stalled.
    assign o_stall   = r_valid & i_stall;
    assign w_advance = ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && i_valid) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

/* sv/csc_out.sv */
// Output register: converts x and y to Q1.16 with rounding and saturation.
module csc_out
    import csc_pkg::*;
#(
    parameter int FRACTION_BITS = CSC_FRACTION_BITS
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_stall,
    input  logic signed [FRACTION_BITS+CSC_XY_GUARD-1:0] i_x,
    input  logic signed [FRACTION_BITS+CSC_XY_GUARD-1:0] i_y,
    output logic                                       o_valid,
    input  logic                                       i_stall,
    output logic signed [CSC_OUT_W-1:0]                o_sine_value,
    output logic signed [CSC_OUT_W-1:0]                o_cosine_value
);

    localparam int XW     = FRACTION_BITS + CSC_XY_GUARD;
    localparam int EW     = XW + 9;
    localparam int SH_DN  = (FRACTION_BITS > 16) ? FRACTION_BITS - 16 : 0;
    localparam int SH_UP  = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
    localparam longint RND = (SH_DN > 0) ? (64'sd1 <<< (SH_DN - 1)) : 64'sd0;

    logic                        r_valid;
    logic signed [CSC_OUT_W-1:0] r_sin, r_cos;
    logic                        w_advance;

    function automatic logic signed [CSC_OUT_W-1:0] to_q16(input logic signed [XW-1:0] v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        e = (e + EW'(RND)) >>> SH_DN;
        e = e <<< SH_UP;
        if (e < EW'(CSC_OUT_MIN)) begin
            e = EW'(CSC_OUT_MIN);
        end else if (e > EW'(CSC_OUT_MAX)) begin
            e = EW'(CSC_OUT_MAX);
        end
        return e[CSC_OUT_W-1:0];
    endfunction

    assign o_stall   = r_valid & i_stall;
    assign w_advance = ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && i_valid) begin
            r_sin <= to_q16(i_y);
            r_cos <= to_q16(i_x);
        end
    end

    assign o_valid        = r_valid;
    assign o_sine_value   = r_sin;
    assign o_cosine_value = r_cos;

endmodule

/* sv/cordic_sine_cosine_unit.sv */
// Rotation-mode CORDIC sine and cosine of an angle in degrees.
// Pipeline: one register per micro-rotation cell, plus the rounding and saturation
// output register.
// Throughput: one word per cycle; every cell takes a new word each cycle unless stalled.
// Stall ripples back through cells that hold a word; empty cells keep filling.
// Reset (synchronous, active low) clears every valid bit; the data registers are not reset.
module cordic_sine_cosine_unit
    import csc_pkg::*;
#(
    parameter int ROTATION_STEPS = CSC_ROTATION_STEPS,
    parameter int FRACTION_BITS  = CSC_FRACTION_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [CSC_ANGLE_W-1:0] i_angle_deg,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [CSC_OUT_W-1:0]  o_sine_value,
    output logic signed [CSC_OUT_W-1:0]  o_cosine_value
);

    localparam int XW     = FRACTION_BITS + CSC_XY_GUARD;
    localparam int NSTEPS = (ROTATION_STEPS < CSC_ATAN_LEN) ? ROTATION_STEPS : CSC_ATAN_LEN;

    logic                      w_valid [NSTEPS+1];
    logic                      w_stall [NSTEPS+1];
    logic signed [XW-1:0]      w_x     [NSTEPS+1];
    logic signed [XW-1:0]      w_y     [NSTEPS+1];
    logic signed [CSC_Z_W-1:0] w_z     [NSTEPS+1];

    assign w_valid[0] = i_valid;
    assign o_stall    = w_stall[0];
    assign w_x[0]     = XW'(csc_start_x(FRACTION_BITS));
    assign w_y[0]     = '0;
    assign w_z[0]     = CSC_Z_W'(i_angle_deg);

    for (genvar g = 0; g < NSTEPS; g++) begin : g_cell
        csc_cell #(
            .FRACTION_BITS (FRACTION_BITS),
            .STEP_IDX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_stall (w_stall[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .o_valid (w_valid[g+1]),
            .i_stall (w_stall[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1])
        );
    end

    csc_out #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_valid[NSTEPS]),
        .o_stall        (w_stall[NSTEPS]),
        .i_x            (w_x[NSTEPS]),
        .i_y            (w_y[NSTEPS]),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sine_value   (o_sine_value),
        .o_cosine_value (o_cosine_value)
    );

endmodule
